[design/rmth_pkg.sv]
// ----------------------------------------------------------------------------
// rmth_pkg
// Types and helpers shared by the running median core and its heap engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rmth_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned MedianW = 33;
  localparam int unsigned CountW  = 11;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    H_IDLE,
    H_UP_CHK,
    H_UP_CMP,
    H_DN_L,
    H_DN_R,
    H_DN_CMP
  } heap_state_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_OUT
  } core_state_e;

  typedef struct packed {
    logic                      push;
    logic                      replace;
    logic signed [SampleW-1:0] value;
  } heap_cmd_t;

  typedef struct packed {
    logic                      busy;
    logic signed [SampleW-1:0] top;
  } heap_stat_t;

  function automatic logic ranks_above(logic signed [SampleW-1:0] a,
                                       logic signed [SampleW-1:0] b,
                                       logic is_max);
    ranks_above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

[design/rmth_heap.sv]
// ----------------------------------------------------------------------------
// rmth_heap
// One binary heap held in a synchronous memory, with push (sift up) and
// replace-top (sift down) walks.
// ----------------------------------------------------------------------------
`default_nettype none

module rmth_heap #(
  parameter int unsigned DEPTH  = 512,
  parameter bit          IS_MAX = 1'b1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rmth_pkg::heap_cmd_t          cmd_i,
  output rmth_pkg::heap_stat_t              stat_o,
  output logic [$clog2(DEPTH+1)-1:0]        size_o
);
  import rmth_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = $clog2(DEPTH + 1);
  localparam int unsigned PW = SW + 1;

  logic signed [SampleW-1:0] mem [DEPTH];

  heap_state_e state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [SW-1:0] n_q, n_d;
  logic [SW-1:0] size_q, size_d;
  logic signed [SampleW-1:0] x_q, x_d;
  logic signed [SampleW-1:0] ldat_q, ldat_d;
  logic hasr_q, hasr_d;
  logic signed [SampleW-1:0] rdata_q;
  logic signed [SampleW-1:0] top_q;

  logic [PW-1:0] child_l, child_r, parent;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic signed [SampleW-1:0] wdata;
  logic l_wins, r_wins;
  logic signed [SampleW-1:0] best_v;
  logic [PW-1:0] best_p;

  assign child_l = (pos_q << 1) + PW'(1);
  assign child_r = child_l + PW'(1);
  assign parent  = (pos_q - PW'(1)) >> 1;

  assign l_wins = ranks_above(ldat_q, x_q, IS_MAX);
  assign r_wins = hasr_q && ranks_above(rdata_q, l_wins ? ldat_q : x_q, IS_MAX);
  assign best_v = r_wins ? rdata_q : ldat_q;
  assign best_p = r_wins ? child_r : child_l;

  always_comb begin
    state_d = state_q;
    case (state_q)
      H_IDLE: begin
        if (cmd_i.replace) begin
          state_d = H_DN_L;
        end else if (cmd_i.push) begin
          state_d = H_UP_CHK;
        end
      end
      H_UP_CHK: begin
        if (pos_q != '0) state_d = H_UP_CMP;
        else             state_d = H_IDLE;
      end
      H_UP_CMP: begin
        if (ranks_above(x_q, rdata_q, IS_MAX)) state_d = H_UP_CHK;
        else                                   state_d = H_IDLE;
      end
      H_DN_L: begin
        if (child_l >= PW'(n_q)) state_d = H_IDLE;
        else                     state_d = H_DN_R;
      end
      H_DN_R:   state_d = H_DN_CMP;
      H_DN_CMP: begin
        if (l_wins || r_wins) state_d = H_DN_L;
        else                  state_d = H_IDLE;
      end
      default:  state_d = H_IDLE;
    endcase
  end

  always_comb begin
    pos_d  = pos_q;
    n_d    = n_q;
    size_d = size_q;
    x_d    = x_q;
    ldat_d = ldat_q;
    hasr_d = hasr_q;
    raddr  = '0;
    waddr  = AW'(pos_q);
    wdata  = x_q;
    we     = 1'b0;
    case (state_q)
      H_IDLE: begin
        x_d = cmd_i.value;
        n_d = size_q;
        if (cmd_i.replace) begin
          pos_d = '0;
        end else if (cmd_i.push) begin
          pos_d  = PW'(size_q);
          size_d = size_q + SW'(1);
        end
      end
      H_UP_CHK: begin
        raddr = AW'(parent);
        if (pos_q == '0) we = 1'b1;
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (ranks_above(x_q, rdata_q, IS_MAX)) begin
          wdata = rdata_q;
          pos_d = parent;
        end
      end
      H_DN_L: begin
        raddr = AW'(child_l);
        if (child_l >= PW'(n_q)) we = 1'b1;
      end
      H_DN_R: begin
        ldat_d = rdata_q;
        raddr  = AW'(child_r);
        hasr_d = child_r < PW'(n_q);
      end
      H_DN_CMP: begin
        we = 1'b1;
        if (l_wins || r_wins) begin
          wdata = best_v;
          pos_d = best_p;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      size_q  <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    n_q    <= n_d;
    x_q    <= x_d;
    ldat_q <= ldat_d;
    hasr_q <= hasr_d;
    if (we && waddr == '0) top_q <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign stat_o.busy = (state_q != H_IDLE);
  assign stat_o.top  = top_q;
  assign size_o      = size_q;

endmodule

`default_nettype wire

[design/running_median_two_heaps_core.sv]
// ----------------------------------------------------------------------------
// running_median_two_heaps_core
// Running median of signed samples kept in a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// Slave stream takes one 32-bit signed sample per transaction. Master stream
// returns one result per sample: twice the median (33 bits, signed), the
// stored count and an overflow flag.
// One sample is in flight at a time. After acceptance the two heaps work in
// parallel: a push walks up one level per read and compare step, a replace of
// the top walks down one level per left read, right read and compare step,
// each through one memory port. The next sample is taken the cycle after the
// result is taken. While the receiver stalls the result holds and tready
// stays low. When CAPACITY samples are held, further samples are dropped and
// flagged. Reset empties both heaps at once; memory contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_two_heaps_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // sample[31:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // median_twice[32:0], stored_count[43:33], overflow[44]
  output logic [rmth_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rmth_pkg::*;

  localparam int unsigned LDEPTH = CAPACITY / 2;
  localparam int unsigned UDEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned LSW    = $clog2(LDEPTH + 1);
  localparam int unsigned USW    = $clog2(UDEPTH + 1);
  localparam int unsigned CW     = $clog2(CAPACITY + 1);

  core_state_e state_q, state_d;
  heap_cmd_t   lcmd, ucmd;
  heap_stat_t  lstat, ustat;
  logic [LSW-1:0] lsize;
  logic [USW-1:0] usize;
  logic [CW-1:0]  cnt;
  logic signed [SampleW-1:0] v;
  logic accept, full, low_swap, up_swap;
  logic ovf_q, ovf_d;
  logic signed [MedianW-1:0] med_q, med_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  assign v        = s_axis_tdata_i;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt      = CW'(lsize) + CW'(usize);
  assign full     = cnt >= CW'(CAPACITY);
  assign low_swap = (lsize != '0) && (v < lstat.top);
  assign up_swap  = (usize != '0) && (v > ustat.top);

  always_comb begin
    lcmd = '0;
    ucmd = '0;
    if (accept && !full) begin
      if (!cnt[0]) begin
        lcmd.replace = low_swap;
        lcmd.value   = v;
        ucmd.push    = 1'b1;
        ucmd.value   = low_swap ? lstat.top : v;
      end else begin
        ucmd.replace = up_swap;
        ucmd.value   = v;
        lcmd.push    = 1'b1;
        lcmd.value   = up_swap ? ustat.top : v;
      end
    end
  end

  rmth_heap #(.DEPTH(LDEPTH), .IS_MAX(1'b1)) u_lower (
    .clk_i, .rst_ni, .cmd_i(lcmd), .stat_o(lstat), .size_o(lsize)
  );

  rmth_heap #(.DEPTH(UDEPTH), .IS_MAX(1'b0)) u_upper (
    .clk_i, .rst_ni, .cmd_i(ucmd), .stat_o(ustat), .size_o(usize)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_WAIT;
      S_WAIT: if (!lstat.busy && !ustat.busy) state_d = S_OUT;
      S_OUT:  if (m_axis_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovf_d = ovf_q;
    med_d = med_q;
    cnt_d = cnt_q;
    if (accept) ovf_d = full;
    if (state_q == S_WAIT) begin
      cnt_d = CountW'(cnt);
      if (cnt[0]) begin
        med_d = (usize != '0) ? ({ustat.top[SampleW-1], ustat.top} <<< 1) : '0;
      end else if (lsize != '0 && usize != '0) begin
        med_d = MedianW'(lstat.top) + MedianW'(ustat.top);
      end else begin
        med_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    med_q <= med_d;
    cnt_q <= cnt_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = {3'b000, ovf_q, cnt_q, med_q};

endmodule

`default_nettype wire

[design/running_median_two_heaps_checker.sv]
// ----------------------------------------------------------------------------
// running_median_two_heaps_checker
// Port-level assertions for the running median core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_two_heaps_checker #(
  parameter int unsigned CAPACITY = 1024
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("new sample taken while a result waits");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second sample taken before first completed");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[44] |-> m_axis_tdata_o[43:33] == 11'(CAPACITY))
    else $error("overflow flagged while store not full");

endmodule

bind running_median_two_heaps_core running_median_two_heaps_checker #(
  .CAPACITY(CAPACITY)
) u_checker (.*);

`default_nettype wire
